// ===== hw/rtl/rgbramp_pkg.sv =====
// Shared types and constants for the RGB332 gradient ramp.
// Holds the controller-to-datapath command and status words and the channel codes.
// Depends on nothing.
package rgbramp_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned ColourW    = 8;
  localparam int unsigned CountW     = 7;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned AccW       = 16;
  localparam int unsigned ChanW      = 3;
  localparam int unsigned DivW       = 11;
  localparam int unsigned BitCntW    = 4;

  localparam logic [7:0]        HalfBias = 8'h80;
  localparam logic [CountW-1:0] CountMin = CountW'(2);
  localparam logic [CountW-1:0] CountMax = CountW'(MaxEntries);

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  typedef struct packed {
    logic  load;
    logic  div_init;
    logic  div_step;
    logic  div_commit;
    logic  emit_step;
    chan_e chan;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

// ===== hw/rtl/rgb332_gradient_ramp.sv =====
// RGB332 gradient ramp, top level.
// Takes a start word (start with from_colour_i, to_colour_i, entry_count_i),
// accepted on a rising edge where start is high and busy is low.
// The count is clamped to 2..64; the ramp then emits that many entries, each
// shown for one cycle with result_valid_o high, entry_index_o counting from 0
// and last_o high on the final one.
// After a load come three serial divisions (one quotient bit a cycle through
// a single shared divider), after which entries leave one a cycle; busy falls
// as the final entry is registered, so the next start word may be taken while
// that entry is on the result ports.
// The receiver cannot stall: every result word is taken in the cycle it shows.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle and
// drops result_valid_o; datapath registers keep their values until reloaded.
// Depends on rgbramp_pkg, rgbramp_ctrl and rgbramp_dp.
module rgb332_gradient_ramp (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] from_colour_i,
  input  logic [7:0] to_colour_i,
  input  logic [6:0] entry_count_i,
  output logic       result_valid_o,
  output logic [5:0] entry_index_o,
  output logic [7:0] colour_o,
  output logic       last_o
);
  import rgbramp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rgbramp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  rgbramp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .from_colour_i  (from_colour_i),
    .to_colour_i    (to_colour_i),
    .entry_count_i  (entry_count_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .entry_index_o  (entry_index_o),
    .colour_o       (colour_o),
    .last_o         (last_o)
  );

endmodule

// ===== hw/rtl/rgbramp_ctrl.sv =====
// Controller for the RGB332 gradient ramp: sequences load, three serial
// divisions and the emission of entries. Depends on rgbramp_pkg.
module rgbramp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output rgbramp_pkg::cmd_t   cmd_o,
  input  rgbramp_pkg::sts_t   sts_i
);
  import rgbramp_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDivInit,
    StDivRun,
    StDivDone,
    StEmit
  } state_e;

  state_e               state_q, state_d;
  chan_e                chan_q, chan_d;
  logic [BitCntW-1:0]   bitcnt_q, bitcnt_d;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d  = state_q;
    chan_d   = chan_q;
    bitcnt_d = bitcnt_q;
    cmd_o    = '{load: 1'b0, div_init: 1'b0, div_step: 1'b0, div_commit: 1'b0,
                 emit_step: 1'b0, chan: chan_q};
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          chan_d     = CH_RED;
          state_d    = StDivInit;
        end
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        bitcnt_d       = '0;
        state_d        = StDivRun;
      end
      StDivRun: begin
        cmd_o.div_step = 1'b1;
        bitcnt_d       = bitcnt_q + BitCntW'(1);
        if (bitcnt_q == BitCntW'(DivW - 1)) begin
          state_d = StDivDone;
        end
      end
      StDivDone: begin
        cmd_o.div_commit = 1'b1;
        case (chan_q)
          CH_RED:   begin chan_d = CH_GREEN; state_d = StDivInit; end
          CH_GREEN: begin chan_d = CH_BLUE;  state_d = StDivInit; end
          default:  begin state_d = StEmit; end
        endcase
      end
      StEmit: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      chan_q   <= CH_RED;
      bitcnt_q <= '0;
    end else begin
      state_q  <= state_d;
      chan_q   <= chan_d;
      bitcnt_q <= bitcnt_d;
    end
  end

  a_start_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == StDivInit && chan_q == CH_RED))
    else $error("load did not begin the red division");

  a_bitcnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivRun) |-> (bitcnt_q <= BitCntW'(DivW - 1)))
    else $error("division step counter overran");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && sts_i.last) |=> !busy_o)
    else $error("controller stayed busy after the final entry");

endmodule

// ===== hw/rtl/rgbramp_dp.sv =====
// Datapath for the RGB332 gradient ramp: anchors, shared serial divider,
// step deltas, 8.8 accumulators and the registered result word.
// Depends on rgbramp_pkg.
module rgbramp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          from_colour_i,
  input  logic [7:0]          to_colour_i,
  input  logic [6:0]          entry_count_i,
  input  rgbramp_pkg::cmd_t   cmd_i,
  output rgbramp_pkg::sts_t   sts_o,
  output logic                result_valid_o,
  output logic [5:0]          entry_index_o,
  output logic [7:0]          colour_o,
  output logic                last_o
);
  import rgbramp_pkg::*;

  logic [ColourW-1:0] from_q, to_q;
  logic [IdxW-1:0]    steps_q, idx_q;
  logic [CountW-1:0]  count_sat;
  logic [AccW-1:0]    acc_r_q, acc_g_q, acc_b_q;
  logic [AccW-1:0]    dr_q, dg_q, db_q;
  logic [IdxW-1:0]    rem_q;
  logic [DivW-1:0]    quo_q;
  logic               neg_q;
  logic               valid_q;
  logic [IdxW-1:0]    idx_out_q;
  logic [ColourW-1:0] colour_q;
  logic               last_q;

  logic [ChanW-1:0]   f_ch, t_ch, mag;
  logic [IdxW:0]      rem_sh;
  logic               ge;
  logic [AccW-1:0]    quot_ext, delta;

  always_comb begin
    count_sat = entry_count_i;
    if (entry_count_i < CountMin) begin
      count_sat = CountMin;
    end else if (entry_count_i > CountMax) begin
      count_sat = CountMax;
    end
  end

  always_comb begin
    case (cmd_i.chan)
      CH_RED:   begin f_ch = from_q[7:5]; t_ch = to_q[7:5]; end
      CH_GREEN: begin f_ch = from_q[4:2]; t_ch = to_q[4:2]; end
      default:  begin f_ch = {1'b0, from_q[1:0]}; t_ch = {1'b0, to_q[1:0]}; end
    endcase
    mag = (t_ch >= f_ch) ? (t_ch - f_ch) : (f_ch - t_ch);
  end

  assign rem_sh   = {rem_q, quo_q[DivW-1]};
  assign ge       = (rem_sh >= {1'b0, steps_q});
  assign quot_ext = AccW'(quo_q);
  assign delta    = neg_q ? (~quot_ext + AccW'(1)) : quot_ext;

  assign sts_o.last = (idx_q == steps_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      from_q  <= from_colour_i;
      to_q    <= to_colour_i;
      steps_q <= IdxW'(count_sat - CountW'(1));
      idx_q   <= '0;
      acc_r_q <= {5'b0, from_colour_i[7:5], HalfBias};
      acc_g_q <= {5'b0, from_colour_i[4:2], HalfBias};
      acc_b_q <= {6'b0, from_colour_i[1:0], HalfBias};
    end
    if (cmd_i.div_init) begin
      neg_q <= (t_ch < f_ch);
      rem_q <= '0;
      quo_q <= {mag, 8'h00};
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? IdxW'(rem_sh - {1'b0, steps_q}) : rem_sh[IdxW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
    if (cmd_i.div_commit) begin
      case (cmd_i.chan)
        CH_RED:   dr_q <= delta;
        CH_GREEN: dg_q <= delta;
        default:  db_q <= delta;
      endcase
    end
    if (cmd_i.emit_step) begin
      idx_out_q <= idx_q;
      colour_q  <= {acc_r_q[10:8], acc_g_q[10:8], acc_b_q[9:8]};
      last_q    <= sts_o.last;
      idx_q     <= idx_q + IdxW'(1);
      acc_r_q   <= acc_r_q + dr_q;
      acc_g_q   <= acc_g_q + dg_q;
      acc_b_q   <= acc_b_q + db_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_step;
    end
  end

  assign result_valid_o = valid_q;
  assign entry_index_o  = idx_out_q;
  assign colour_o       = colour_q;
  assign last_o         = last_q;

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < steps_q))
    else $error("divider remainder not below divisor");

  a_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step |=> valid_q)
    else $error("emitted entry missing from result word");

  a_first_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (idx_q == '0))
    else $error("entry index not cleared on load");

endmodule

// ===== verif/rgbramp_checker.sv =====
// Checker for the RGB332 gradient ramp: watches the start and result channels.
// Predicts every palette entry of each accepted ramp and compares field by field.
// Depends on rgbramp_pkg.
module rgbramp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [rgbramp_pkg::ColourW-1:0] from_colour_i,
  input  logic [rgbramp_pkg::ColourW-1:0] to_colour_i,
  input  logic [rgbramp_pkg::CountW-1:0]  entry_count_i,
  input  logic                            result_valid_i,
  input  logic [rgbramp_pkg::IdxW-1:0]    entry_index_i,
  input  logic [rgbramp_pkg::ColourW-1:0] colour_i,
  input  logic                            last_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import rgbramp_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]    index;
    logic [ColourW-1:0] colour;
    logic               last;
  } palette_entry_t;

  palette_entry_t ramp_due[$];

  function automatic int chan_step(input logic [ChanW-1:0] from_ch,
                                   input logic [ChanW-1:0] to_ch, input int steps);
    return ((int'(to_ch) - int'(from_ch)) * 256) / steps;
  endfunction

  function automatic void queue_ramp(input logic [ColourW-1:0] from_c,
                                     input logic [ColourW-1:0] to_c,
                                     input logic [CountW-1:0] count_raw);
    logic [AccW-1:0] acc_r, acc_g, acc_b;
    int count, steps, step_r, step_g, step_b;
    palette_entry_t e;
    count = int'(count_raw);
    if (count < int'(CountMin)) count = int'(CountMin);
    if (count > int'(MaxEntries)) count = int'(MaxEntries);
    steps  = count - 1;
    acc_r  = {5'b0, from_c[7:5], HalfBias};
    acc_g  = {5'b0, from_c[4:2], HalfBias};
    acc_b  = {6'b0, from_c[1:0], HalfBias};
    step_r = chan_step(from_c[7:5], to_c[7:5], steps);
    step_g = chan_step(from_c[4:2], to_c[4:2], steps);
    step_b = chan_step({1'b0, from_c[1:0]}, {1'b0, to_c[1:0]}, steps);
    for (int i = 0; i <= steps; i++) begin
      e.index  = IdxW'(i);
      e.colour = {acc_r[10:8], acc_g[10:8], acc_b[9:8]};
      e.last   = (i == steps);
      ramp_due.push_back(e);
      acc_r = acc_r + AccW'(step_r);
      acc_g = acc_g + AccW'(step_g);
      acc_b = acc_b + AccW'(step_b);
    end
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i) begin
    palette_entry_t want;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (ramp_due.size() == 0) begin
          $error("entry %0d with colour %0h arrived with none outstanding",
                 entry_index_i, colour_i);
          fail_count_o++;
        end else begin
          want = ramp_due.pop_front();
          checked_o++;
          if (entry_index_i !== want.index) begin
            $error("entry_index: expected %0d, got %0d", want.index, entry_index_i);
            fail_count_o++;
          end
          if (colour_i !== want.colour) begin
            $error("colour: expected %02h, got %02h", want.colour, colour_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) queue_ramp(from_colour_i, to_colour_i, entry_count_i);
      pending_o = ramp_due.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the RGB332 gradient ramp: clock, reset, start words and verdict.
// Directed corner ramps, then random ramps; random hold-offs, off mid-run; a watchdog.
// Depends on rgbramp_pkg, rgb332_gradient_ramp and rgbramp_checker.
module tb_top;
  import rgbramp_pkg::*;

  localparam int StallLimit = 3000;
  localparam int RandomRamps = 240;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [ColourW-1:0] from_colour;
  logic [ColourW-1:0] to_colour;
  logic [CountW-1:0]  entry_count;
  logic               result_valid;
  logic [IdxW-1:0]    entry_index;
  logic [ColourW-1:0] colour;
  logic               last;

  int fail_count, pending, checked;
  int ramps_sent;
  int idle_pct;
  int stall_cycles;

  rgb332_gradient_ramp dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .from_colour_i  (from_colour),
    .to_colour_i    (to_colour),
    .entry_count_i  (entry_count),
    .result_valid_o (result_valid),
    .entry_index_o  (entry_index),
    .colour_o       (colour),
    .last_o         (last)
  );

  rgbramp_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .from_colour_i  (from_colour),
    .to_colour_i    (to_colour),
    .entry_count_i  (entry_count),
    .result_valid_i (result_valid),
    .entry_index_i  (entry_index),
    .colour_i       (colour),
    .last_i         (last),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial stall_cycles = 0;

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // present the word, dropping start at random each cycle until it is taken
  task automatic send_ramp(input logic [ColourW-1:0] from_c, input logic [ColourW-1:0] to_c,
                           input logic [CountW-1:0] count);
    logic taken;
    @(negedge clk_i);
    from_colour <= from_c;
    to_colour   <= to_c;
    entry_count <= count;
    do begin
      start <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
      @(posedge clk_i);
      taken = start && !busy;
      if (!taken) @(negedge clk_i);
    end while (!taken);
    ramps_sent++;
  endtask

  initial begin
    logic [CountW-1:0] count;
    rst_ni      = 1'b0;
    start       = 1'b0;
    from_colour = '0;
    to_colour   = '0;
    entry_count = '0;
    ramps_sent  = 0;
    idle_pct    = 24;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_ramp(8'h00, 8'hFF, 7'd0);
    send_ramp(8'hFF, 8'h00, 7'd1);
    send_ramp(8'h00, 8'hFF, 7'd2);
    send_ramp(8'hFF, 8'h00, 7'd3);
    send_ramp(8'h00, 8'hFF, 7'd64);
    send_ramp(8'hFF, 8'h00, 7'd64);
    send_ramp(8'h5A, 8'hA5, 7'd65);
    send_ramp(8'hA5, 8'h5A, 7'd127);
    send_ramp(8'h6D, 8'h6D, 7'd10);
    send_ramp(8'hE0, 8'h00, 7'd63);
    send_ramp(8'h1C, 8'h00, 7'd50);
    send_ramp(8'h03, 8'h00, 7'd64);
    send_ramp(8'h00, 8'hE0, 7'd7);
    send_ramp(8'h00, 8'h1C, 7'd9);
    send_ramp(8'h00, 8'h03, 7'd4);
    send_ramp(8'h20, 8'hC0, 7'd33);
    send_ramp(8'h92, 8'h49, 7'd32);
    send_ramp(8'h01, 8'h02, 7'd64);
    send_ramp(8'hFF, 8'hFF, 7'd64);
    send_ramp(8'h00, 8'h00, 7'd5);

    for (int n = 0; n < RandomRamps; n++) begin
      idle_pct = (n >= 100 && n < 160) ? 0 : 24;
      if ($urandom_range(99) < 85) count = CountW'($urandom_range(2, 64));
      else count = CountW'($urandom_range(0, 127));
      send_ramp(ColourW'($urandom_range(0, 255)), ColourW'($urandom_range(0, 255)), count);
    end
    @(negedge clk_i);
    start <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (120) @(negedge clk_i);

    $display("Ran %0d ramps (directed corners and random anchors), %0d entries checked",
             ramps_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
